@@ rtl/core/xrng_pkg.sv @@
// Package for the xoroshiro128** range generator: payload structs, request codes,
// register indexes, sequencer states and the generator's shift constants.
// No dependencies.
package xrng_pkg;

  localparam int unsigned WORD_W    = 64;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CNT_W     = 6;

  localparam logic [1:0] REQ_RAW   = 2'd0;
  localparam logic [1:0] REQ_RANGE = 2'd1;
  localparam logic [1:0] REQ_FRAC  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SEED_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED_B = 2'd1;

  localparam int unsigned ROT_SCRAMBLE = 7;
  localparam int unsigned ROT_A        = 24;
  localparam int unsigned SHL_B        = 16;
  localparam int unsigned ROT_B        = 37;
  localparam int unsigned FRAC_SHIFT   = 11;

  localparam logic [CNT_W-1:0] DIV_LAST = 6'd63;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [WORD_W-1:0] range_min;
    logic [WORD_W-1:0] range_max;
  } xrng_req_t;

  typedef struct packed {
    logic [WORD_W-1:0] value;
  } xrng_rsp_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] reg_index;
    logic [WORD_W-1:0]    reg_wdata;
  } xrng_cfg_t;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SCRAM = 6'b000010,
    ST_MUL9  = 6'b000100,
    ST_DIV   = 6'b001000,
    ST_ADD   = 6'b010000,
    ST_OUT   = 6'b100000
  } xrng_state_t;

  function automatic logic [WORD_W-1:0] rotl64(input logic [WORD_W-1:0] x,
                                               input int unsigned k);
    rotl64 = (x << k) | (x >> (WORD_W - k));
  endfunction

endpackage

@@ rtl/core/xrng_chan_if.sv @@
// Valid/ready channel interface carrying one payload struct per request.
// The payload type is set where the channel is instantiated.
interface xrng_chan_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface

@@ rtl/core/xoroshiro128ss_range_generator_unit.sv @@
// Top level of the xoroshiro128** range generator: generator state, scrambler,
// bit-serial modulo unit and output register. Uses xrng_pkg and xrng_chan_if.
//
// Channel   Dir  Payload                          Accepted when
// in_req    in   req_type, range_min, range_max   valid && ready
// out_rsp   out  value                            valid && ready
// cfg_wr    in   reg_index, reg_wdata             valid && ready
//
// Raw and fraction requests pass through the scrambler and multiply steps; range
// requests also pass through the restoring divider, which retires one quotient bit
// per cycle, and the add step. Equal bounds and unused codes go straight to output.
// Reset loads both seeds and both state words with 1.
// The result register holds a finished word until out_rsp takes it; in_req is
// ready only while the sequencer is idle, and a result waits if the register is full.
module xoroshiro128ss_range_generator_unit (
  input logic        clk,
  input logic        rst_n,
  xrng_chan_if.sink   in_req,
  xrng_chan_if.source out_rsp,
  xrng_chan_if.sink   cfg_wr
);

  import xrng_pkg::*;

  xrng_state_t       fsm_r, fsm_nxt;
  logic [WORD_W-1:0] seed_a_r, seed_a_nxt;
  logic [WORD_W-1:0] seed_b_r, seed_b_nxt;
  logic [WORD_W-1:0] state_a_r, state_a_nxt;
  logic [WORD_W-1:0] state_b_r, state_b_nxt;
  logic [1:0]        type_r, type_nxt;
  logic [WORD_W-1:0] lo_r, lo_nxt;
  logic [WORD_W-1:0] span_r, span_nxt;
  logic [WORD_W-1:0] scr_r, scr_nxt;
  logic [WORD_W-1:0] acc_r, acc_nxt;
  logic [WORD_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] out_value_r, out_value_nxt;

  logic              in_fire;
  logic              cfg_fire;
  logic [WORD_W-1:0] xb;
  logic [WORD_W-1:0] word;
  logic [WORD_W:0]   rem_sh;
  logic [WORD_W+1:0] trial;

  assign in_req.ready      = (fsm_r == ST_IDLE);
  assign cfg_wr.ready      = (fsm_r == ST_IDLE);
  assign in_fire           = in_req.valid && in_req.ready;
  assign cfg_fire          = cfg_wr.valid && cfg_wr.ready;
  assign out_rsp.valid     = out_valid_r;
  assign out_rsp.data.value = out_value_r;

  assign xb     = state_b_r ^ state_a_r;
  assign word   = scr_r + (scr_r << 3);
  assign rem_sh = {rem_r, acc_r[WORD_W-1]};
  assign trial  = {1'b0, rem_sh} - {2'b00, span_r};

  always_comb begin
    fsm_nxt       = fsm_r;
    seed_a_nxt    = seed_a_r;
    seed_b_nxt    = seed_b_r;
    state_a_nxt   = state_a_r;
    state_b_nxt   = state_b_r;
    type_nxt      = type_r;
    lo_nxt        = lo_r;
    span_nxt      = span_r;
    scr_nxt       = scr_r;
    acc_nxt       = acc_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;

    if (out_valid_r && out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_fire) begin
      case (cfg_wr.data.reg_index)
        CFG_SEED_A: begin
          seed_a_nxt  = cfg_wr.data.reg_wdata;
          state_a_nxt = cfg_wr.data.reg_wdata;
          state_b_nxt = seed_b_r;
        end
        CFG_SEED_B: begin
          seed_b_nxt  = cfg_wr.data.reg_wdata;
          state_a_nxt = seed_a_r;
          state_b_nxt = cfg_wr.data.reg_wdata;
        end
        default: ;
      endcase
    end

    case (fsm_r)
      ST_IDLE: begin
        if (in_fire) begin
          type_nxt = in_req.data.req_type;
          lo_nxt   = in_req.data.range_min;
          span_nxt = in_req.data.range_max - in_req.data.range_min;
          case (in_req.data.req_type)
            REQ_RAW, REQ_FRAC: begin
              fsm_nxt = ST_SCRAM;
            end
            REQ_RANGE: begin
              if (in_req.data.range_min == in_req.data.range_max) begin
                acc_nxt = in_req.data.range_min;
                fsm_nxt = ST_OUT;
              end else begin
                fsm_nxt = ST_SCRAM;
              end
            end
            default: begin
              acc_nxt = '0;
              fsm_nxt = ST_OUT;
            end
          endcase
        end
      end
      ST_SCRAM: begin
        scr_nxt     = rotl64(state_a_r + (state_a_r << 2), ROT_SCRAMBLE);
        state_a_nxt = rotl64(state_a_r, ROT_A) ^ xb ^ (xb << SHL_B);
        state_b_nxt = rotl64(xb, ROT_B);
        fsm_nxt     = ST_MUL9;
      end
      ST_MUL9: begin
        case (type_r)
          REQ_RANGE: begin
            acc_nxt = word;
            rem_nxt = '0;
            cnt_nxt = '0;
            fsm_nxt = ST_DIV;
          end
          REQ_FRAC: begin
            acc_nxt = word >> FRAC_SHIFT;
            fsm_nxt = ST_OUT;
          end
          default: begin
            acc_nxt = word;
            fsm_nxt = ST_OUT;
          end
        endcase
      end
      ST_DIV: begin
        rem_nxt = trial[WORD_W+1] ? rem_sh[WORD_W-1:0] : trial[WORD_W-1:0];
        acc_nxt = acc_r << 1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) begin
          fsm_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        acc_nxt = rem_r + lo_r;
        fsm_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = acc_r;
          fsm_nxt       = ST_IDLE;
        end
      end
      default: begin
        fsm_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r       <= ST_IDLE;
      seed_a_r    <= 64'd1;
      seed_b_r    <= 64'd1;
      state_a_r   <= 64'd1;
      state_b_r   <= 64'd1;
      out_valid_r <= 1'b0;
    end else begin
      fsm_r       <= fsm_nxt;
      seed_a_r    <= seed_a_nxt;
      seed_b_r    <= seed_b_nxt;
      state_a_r   <= state_a_nxt;
      state_b_r   <= state_b_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    type_r      <= type_nxt;
    lo_r        <= lo_nxt;
    span_r      <= span_nxt;
    scr_r       <= scr_nxt;
    acc_r       <= acc_nxt;
    rem_r       <= rem_nxt;
    cnt_r       <= cnt_nxt;
    out_value_r <= out_value_nxt;
  end

  a_rem_below_span: assert property (@(posedge clk) disable iff (!rst_n)
    fsm_r == ST_DIV |-> rem_r < span_r)
    else $error("divider remainder not below span");

  a_unused_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_req.data.req_type != REQ_RAW && in_req.data.req_type != REQ_RANGE &&
    in_req.data.req_type != REQ_FRAC |=> fsm_r == ST_OUT && acc_r == '0)
    else $error("unused request code did not yield zero");

  a_seed_a_reload: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_fire && cfg_wr.data.reg_index == CFG_SEED_A
    |=> state_a_r == $past(cfg_wr.data.reg_wdata) && state_b_r == seed_b_r)
    else $error("seed write did not reload state");

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(fsm_r) == ST_OUT)
    else $error("result raised outside output step");

endmodule
